>>> rtl/core/mevq_pkg.sv
`timescale 1ns / 1ps

package mevq_pkg;

   // Field widths
   localparam int CFG_W       = 15;
   localparam int POS_W       = 16;
   localparam int CARRY_W     = 17;
   localparam int CSR_INDEX_W = 1;

   // Wheel counts per notch
   localparam int NOTCH_COUNTS = 120;

   // Configuration register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 15'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 15'd480;

   // Message kinds
   localparam logic [2:0] KIND_MOVE  = 3'd0;
   localparam logic [2:0] KIND_LDOWN = 3'd1;
   localparam logic [2:0] KIND_RDOWN = 3'd2;
   localparam logic [2:0] KIND_LUP   = 3'd3;
   localparam logic [2:0] KIND_RUP   = 3'd4;
   localparam logic [2:0] KIND_WHEEL = 3'd5;
   localparam logic [2:0] KIND_READ  = 3'd6;
   localparam logic [2:0] KIND_FLUSH = 3'd7;

   // Result categories
   localparam logic [2:0] CAT_MOTION     = 3'd0;
   localparam logic [2:0] CAT_WHEEL_DOWN = 3'd5;
   localparam logic [2:0] CAT_WHEEL_UP   = 3'd6;
   localparam logic [2:0] CAT_NONE       = 3'd7;

   // Event types
   localparam logic [3:0] EV_MOVE      = 4'd0;
   localparam logic [3:0] EV_LEAVE     = 4'd1;
   localparam logic [3:0] EV_ENTER     = 4'd2;
   localparam logic [3:0] EV_LPRESS    = 4'd3;
   localparam logic [3:0] EV_LRELEASE  = 4'd4;
   localparam logic [3:0] EV_RPRESS    = 4'd5;
   localparam logic [3:0] EV_RRELEASE  = 4'd6;
   localparam logic [3:0] EV_WHEELUP   = 4'd7;
   localparam logic [3:0] EV_WHEELDOWN = 4'd8;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    buttons_held;
      logic signed [POS_W-1:0] wheel_turn;
   } req_type;

   typedef struct packed {
      logic [2:0]              category;
      logic                    event_valid;
      logic [3:0]              event_type;
      logic signed [POS_W-1:0] event_x;
      logic signed [POS_W-1:0] event_y;
      logic                    event_left;
      logic                    event_right;
      logic                    capture_set;
      logic                    capture_release;
      logic                    in_window;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } cfg_type;

   // One stored event
   typedef struct packed {
      logic [3:0]       etype;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             left;
      logic             right;
   } entry_type;

   typedef enum logic [1:0] {
      OP_NOP   = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2,
      OP_FLUSH = 2'd3
   } op_code_type;

   // Queue operation from the front to the back; last closes an item
   typedef struct packed {
      op_code_type code;
      logic        last;
      entry_type   entry;
   } op_type;

   // Per-item status latched by the front
   typedef struct packed {
      logic [2:0] category;
      logic       capture_set;
      logic       capture_release;
      logic       in_window;
   } info_type;

   // Completion from the back
   typedef struct packed {
      logic      done;
      logic      pop_ok;
      entry_type entry;
   } done_type;

endpackage

>>> rtl/core/mevq_front.sv
`timescale 1ns / 1ps

module mevq_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  mevq_pkg::req_type   req,
   input  mevq_pkg::cfg_type   cfg,
   input  logic                opq_full,
   output logic                op_valid,
   output mevq_pkg::op_type    op,
   output mevq_pkg::info_type  info
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_FIRST  = 4'b0010,
      S_SECOND = 4'b0100,
      S_WHEEL  = 4'b1000
   } state_type;

   localparam logic signed [mevq_pkg::CARRY_W-1:0] STEP =
      mevq_pkg::CARRY_W'(mevq_pkg::NOTCH_COUNTS);

   state_type state_ff, state_in;

   logic [mevq_pkg::POS_W-1:0]          cur_x_ff, cur_x_in;
   logic [mevq_pkg::POS_W-1:0]          cur_y_ff, cur_y_in;
   logic                                inside_ff, inside_in;
   logic                                left_ff, left_in;
   logic                                right_ff, right_in;
   logic signed [mevq_pkg::CARRY_W-1:0] carry_ff, carry_in;
   mevq_pkg::op_code_type               first_code_ff, first_code_in;
   logic [3:0]                          first_ev_ff, first_ev_in;
   logic                                second_ff, second_in;
   logic [3:0]                          second_ev_ff, second_ev_in;
   mevq_pkg::info_type                  info_ff, info_in;

   logic                                pos_inside;
   logic signed [mevq_pkg::CARRY_W-1:0] carry_step;
   mevq_pkg::entry_type                 snap;

   // Test the message position against the client area
   assign pos_inside = !req.pos_x[mevq_pkg::POS_W-1]
                    && (req.pos_x[mevq_pkg::CFG_W-1:0] < cfg.width)
                    && !req.pos_y[mevq_pkg::POS_W-1]
                    && (req.pos_y[mevq_pkg::CFG_W-1:0] < cfg.height);

   // Snapshot of position and buttons for the event being pushed
   always_comb begin
      snap.etype = mevq_pkg::EV_MOVE;
      snap.x     = cur_x_ff;
      snap.y     = cur_y_ff;
      snap.left  = left_ff;
      snap.right = right_ff;
   end

   // Classify on acceptance, then issue queue operations one a cycle while opq_full is low
   always_comb begin
      state_in      = state_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      inside_in     = inside_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      carry_in      = carry_ff;
      first_code_in = first_code_ff;
      first_ev_in   = first_ev_ff;
      second_in     = second_ff;
      second_ev_in  = second_ev_ff;
      info_in       = info_ff;
      carry_step    = carry_ff;
      op_valid      = 1'b0;
      op            = '0;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               first_code_in        = mevq_pkg::OP_PUSH;
               second_in            = 1'b0;
               info_in.capture_set     = 1'b0;
               info_in.capture_release = 1'b0;
               info_in.category        = req.kind;
               state_in             = S_FIRST;
               case (req.kind)
                  mevq_pkg::KIND_MOVE: begin
                     info_in.category = mevq_pkg::CAT_MOTION;
                     if (pos_inside || req.buttons_held) begin
                        cur_x_in    = req.pos_x;
                        cur_y_in    = req.pos_y;
                        first_ev_in = mevq_pkg::EV_MOVE;
                        if (pos_inside && !inside_ff) begin
                           inside_in           = 1'b1;
                           second_in           = 1'b1;
                           second_ev_in        = mevq_pkg::EV_ENTER;
                           info_in.capture_set = 1'b1;
                        end
                     end else begin
                        inside_in               = 1'b0;
                        first_ev_in             = mevq_pkg::EV_LEAVE;
                        info_in.capture_release = 1'b1;
                     end
                  end
                  mevq_pkg::KIND_LDOWN: begin
                     left_in     = 1'b1;
                     first_ev_in = mevq_pkg::EV_LPRESS;
                  end
                  mevq_pkg::KIND_RDOWN: begin
                     right_in    = 1'b1;
                     first_ev_in = mevq_pkg::EV_RPRESS;
                  end
                  mevq_pkg::KIND_LUP, mevq_pkg::KIND_RUP: begin
                     if (req.kind == mevq_pkg::KIND_LUP) begin
                        left_in     = 1'b0;
                        first_ev_in = mevq_pkg::EV_LRELEASE;
                     end else begin
                        right_in    = 1'b0;
                        first_ev_in = mevq_pkg::EV_RRELEASE;
                     end
                     if (!pos_inside) begin
                        inside_in               = 1'b0;
                        second_in               = 1'b1;
                        second_ev_in            = mevq_pkg::EV_LEAVE;
                        info_in.capture_release = 1'b1;
                     end
                  end
                  mevq_pkg::KIND_WHEEL: begin
                     carry_in = carry_ff
                              + mevq_pkg::CARRY_W'(req.wheel_turn);
                     info_in.category = req.wheel_turn[mevq_pkg::POS_W-1]
                                      ? mevq_pkg::CAT_WHEEL_DOWN
                                      : mevq_pkg::CAT_WHEEL_UP;
                     state_in = S_WHEEL;
                  end
                  mevq_pkg::KIND_READ: begin
                     first_code_in    = mevq_pkg::OP_POP;
                     info_in.category = mevq_pkg::CAT_NONE;
                  end
                  default: begin
                     first_code_in    = mevq_pkg::OP_FLUSH;
                     info_in.category = mevq_pkg::CAT_NONE;
                  end
               endcase
               info_in.in_window = inside_in;
            end
         end
         S_FIRST: begin
            if (!opq_full) begin
               op_valid = 1'b1;
               op.code  = first_code_ff;
               op.last  = !second_ff;
               if (first_code_ff == mevq_pkg::OP_PUSH) begin
                  op.entry       = snap;
                  op.entry.etype = first_ev_ff;
               end
               state_in = second_ff ? S_SECOND : S_IDLE;
            end
         end
         S_SECOND: begin
            if (!opq_full) begin
               op_valid       = 1'b1;
               op.code        = mevq_pkg::OP_PUSH;
               op.last        = 1'b1;
               op.entry       = snap;
               op.entry.etype = second_ev_ff;
               state_in       = S_IDLE;
            end
         end
         S_WHEEL: begin
            // Take one notch off the carry a cycle while opq_full is low
            if (!opq_full) begin
               op_valid = 1'b1;
               if (carry_ff >= STEP) begin
                  carry_step     = carry_ff - STEP;
                  op.code        = mevq_pkg::OP_PUSH;
                  op.entry       = snap;
                  op.entry.etype = mevq_pkg::EV_WHEELUP;
               end else if (carry_ff <= -STEP) begin
                  carry_step     = carry_ff + STEP;
                  op.code        = mevq_pkg::OP_PUSH;
                  op.entry       = snap;
                  op.entry.etype = mevq_pkg::EV_WHEELDOWN;
               end else begin
                  op.code = mevq_pkg::OP_NOP;
               end
               carry_in = carry_step;
               op.last  = (carry_step < STEP) && (carry_step > -STEP);
               if (op.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         inside_ff <= 1'b0;
         left_ff   <= 1'b0;
         right_ff  <= 1'b0;
         carry_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         inside_ff <= inside_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         carry_ff  <= carry_in;
      end
   end

   // Per-item plan and status
   always_ff @(posedge clock) begin
      first_code_ff <= first_code_in;
      first_ev_ff   <= first_ev_in;
      second_ff     <= second_in;
      second_ev_ff  <= second_ev_in;
      info_ff       <= info_in;
   end

   assign info = info_ff;

endmodule

>>> rtl/core/mevq_opq.sv
`timescale 1ns / 1ps

module mevq_opq (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  mevq_pkg::op_type  wr_op,
   output logic              full,
   output logic              rd_valid,
   output mevq_pkg::op_type  rd_op
);

   localparam int DEPTH = 4;

   mevq_pkg::op_type slot_ff [DEPTH];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   assign full     = (count_ff == 3'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_op    = slot_ff[rd_ptr_ff];

   // Advance pointers; the back drains one operation a cycle
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_valid && !full) begin
         wr_ptr_in = wr_ptr_ff + 2'd1;
      end
      if (rd_valid) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + 3'(wr_valid && !full) - 3'(rd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued operations
   always_ff @(posedge clock) begin
      if (wr_valid && !full) begin
         slot_ff[wr_ptr_ff] <= wr_op;
      end
   end

endmodule

>>> rtl/core/mevq_back.sv
`timescale 1ns / 1ps

module mevq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  mevq_pkg::op_type    op,
   output mevq_pkg::done_type  done
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W:0]   WRAP_SUM  = (CNT_W + 1)'(QUEUE_DEPTH);

   mevq_pkg::entry_type store_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                done_ff, done_in;
   logic                pop_ok_ff, pop_ok_in;
   mevq_pkg::entry_type rd_data_ff;

   logic                wr_en;
   logic                rd_en;
   logic [PTR_W-1:0]    wr_addr;
   logic [PTR_W-1:0]    head_next;
   logic [CNT_W:0]      slot_sum;

   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);

   // Carry out one queue operation a cycle
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = head_ff;
      pop_ok_in = 1'b0;
      slot_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (slot_sum >= WRAP_SUM) begin
         slot_sum = slot_sum - WRAP_SUM;
      end
      if (op_valid) begin
         case (op.code)
            mevq_pkg::OP_PUSH: begin
               wr_en = 1'b1;
               if (count_ff < FULL_CNT) begin
                  wr_addr  = slot_sum[PTR_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // Overwrite the oldest entry
                  head_in = head_next;
               end
            end
            mevq_pkg::OP_POP: begin
               if (count_ff != '0) begin
                  rd_en     = 1'b1;
                  pop_ok_in = 1'b1;
                  head_in   = head_next;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            mevq_pkg::OP_FLUSH: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      done_in = op_valid && op.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_ok_ff <= pop_ok_in;
   end

   // Event store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= op.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[head_ff];
      end
   end

   assign done.done   = done_ff;
   assign done.pop_ok = pop_ok_ff;
   assign done.entry  = rd_data_ff;

endmodule

>>> rtl/core/mouse_event_queue.sv
`timescale 1ns / 1ps
// Channel    Handshake                 Payload
// request    start / busy              req_data  (mevq_pkg::req_type)
// result     rsp_valid strobe          rsp_data  (mevq_pkg::rsp_type)
// config     csr_valid / csr_ready     csr_index, csr_data
//
// An item issues at least one queue operation: one push per wheel notch, so a wheel
// item queues as many pushes as its notches. Operations pass from the front through the
// operation queue to the back; the item's last operation ends it with a result strobe.
// The back executes one push, pop or flush a cycle on an event store with one write
// port and one registered read port; the next item is taken at the earliest at the
// edge that ends the strobe cycle.
// Reset clears position, flags, carry and queue pointers; the store needs no clear.
// busy stays high from acceptance until the result strobe; results cannot be held off.

module mouse_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mevq_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output mevq_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mevq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mevq_pkg::CFG_W-1:0]           csr_data
);

   logic               busy_ff, busy_in;
   logic               rsp_valid_ff;
   mevq_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   mevq_pkg::cfg_type  cfg_ff, cfg_in;

   logic               take;
   logic               front_op_valid;
   mevq_pkg::op_type   front_op;
   mevq_pkg::info_type info;
   logic               opq_full;
   logic               back_op_valid;
   mevq_pkg::op_type   back_op;
   mevq_pkg::done_type done;

   assign take      = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mevq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req      (req_data),
      .cfg      (cfg_ff),
      .opq_full (opq_full),
      .op_valid (front_op_valid),
      .op       (front_op),
      .info     (info)
   );

   mevq_opq u_opq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_op_valid),
      .wr_op    (front_op),
      .full     (opq_full),
      .rd_valid (back_op_valid),
      .rd_op    (back_op)
   );

   mevq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (back_op_valid),
      .op       (back_op),
      .done     (done)
   );

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mevq_pkg::CSR_WIDTH:  cfg_in.width  = csr_data;
            mevq_pkg::CSR_HEIGHT: cfg_in.height = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Track the item in flight
   always_comb begin
      busy_in = busy_ff;
      if (take) begin
         busy_in = 1'b1;
      end else if (done.done) begin
         busy_in = 1'b0;
      end
   end

   // Assemble the result transaction
   always_comb begin
      rsp_data_in                 = '0;
      rsp_data_in.category        = info.category;
      rsp_data_in.capture_set     = info.capture_set;
      rsp_data_in.capture_release = info.capture_release;
      rsp_data_in.in_window       = info.in_window;
      if (done.pop_ok) begin
         rsp_data_in.event_valid = 1'b1;
         rsp_data_in.event_type  = done.entry.etype;
         rsp_data_in.event_x     = done.entry.x;
         rsp_data_in.event_y     = done.entry.y;
         rsp_data_in.event_left  = done.entry.left;
         rsp_data_in.event_right = done.entry.right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.width  <= mevq_pkg::WIDTH_RESET;
         cfg_ff.height <= mevq_pkg::HEIGHT_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= done.done;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int QUEUE_DEPTH = 16;
   // Slowest legal run: every item a full-range wheel plus the longest gap, with margin
   localparam int CYCLE_LIMIT = 2000000;
   // Longest single item: a full-range wheel on top of the carry queues 274 notches
   localparam int DRAIN_CYCLES = 300;

   // One pending transaction: a register write or a pointer message
   typedef struct packed {
      logic                             is_cfg;
      logic [mevq_pkg::CSR_INDEX_W-1:0] index;
      logic [mevq_pkg::CFG_W-1:0]       value;
      mevq_pkg::req_type                msg;
   } pending_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   mevq_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   mevq_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [mevq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mevq_pkg::CFG_W-1:0]       csr_data = '0;

   pending_type       pending_work[$];
   mevq_pkg::rsp_type awaited_responses[$];
   int                msgs_sent = 0;
   int                msgs_taken = 0;
   int                writes_sent = 0;
   int                writes_taken = 0;
   int                gap_left = 0;
   logic              no_idle = 1'b0;
   logic              failed = 1'b0;
   int                cycle_count = 0;

   // Predicted block state
   logic [mevq_pkg::CFG_W-1:0] win_w = mevq_pkg::WIDTH_RESET;
   logic [mevq_pkg::CFG_W-1:0] win_h = mevq_pkg::HEIGHT_RESET;
   logic [mevq_pkg::POS_W-1:0] ptr_x = '0;
   logic [mevq_pkg::POS_W-1:0] ptr_y = '0;
   logic                       ptr_inside = 1'b0;
   logic                       left_held = 1'b0;
   logic                       right_held = 1'b0;
   int                         wheel_carry = 0;
   mevq_pkg::entry_type        event_ring[QUEUE_DEPTH];
   int                         ring_head = 0;
   int                         ring_count = 0;

   mouse_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Push an event stamped with the current position and buttons; drop the oldest when full
   function automatic void record_event(logic [3:0] etype);
      mevq_pkg::entry_type e;
      int                  slot;
      e.etype = etype;
      e.x     = ptr_x;
      e.y     = ptr_y;
      e.left  = left_held;
      e.right = right_held;
      if (ring_count < QUEUE_DEPTH) begin
         slot = (ring_head + ring_count) % QUEUE_DEPTH;
         event_ring[slot] = e;
         ring_count++;
      end else begin
         event_ring[ring_head] = e;
         ring_head = (ring_head + 1) % QUEUE_DEPTH;
      end
   endfunction

   // Advance the predicted state by one message and return its response
   function automatic mevq_pkg::rsp_type pointer_response(mevq_pkg::req_type m);
      mevq_pkg::rsp_type r;
      int                mx;
      int                my;
      int                delta;
      logic              on_screen;
      mx = $signed(m.pos_x);
      my = $signed(m.pos_y);
      on_screen = mx >= 0 && mx < int'(win_w) && my >= 0 && my < int'(win_h);
      r = '0;
      case (m.kind)
         mevq_pkg::KIND_MOVE: begin
            if (on_screen || m.buttons_held) begin
               ptr_x = m.pos_x;
               ptr_y = m.pos_y;
               record_event(mevq_pkg::EV_MOVE);
               if (on_screen && !ptr_inside) begin
                  r.capture_set = 1'b1;
                  ptr_inside = 1'b1;
                  record_event(mevq_pkg::EV_ENTER);
               end
            end else begin
               // position is kept; a leave is recorded on every such move
               r.capture_release = 1'b1;
               ptr_inside = 1'b0;
               record_event(mevq_pkg::EV_LEAVE);
            end
            r.category = mevq_pkg::CAT_MOTION;
         end
         mevq_pkg::KIND_LDOWN: begin
            left_held = 1'b1;
            record_event(mevq_pkg::EV_LPRESS);
            r.category = m.kind;
         end
         mevq_pkg::KIND_RDOWN: begin
            right_held = 1'b1;
            record_event(mevq_pkg::EV_RPRESS);
            r.category = m.kind;
         end
         mevq_pkg::KIND_LUP, mevq_pkg::KIND_RUP: begin
            if (m.kind == mevq_pkg::KIND_LUP) begin
               left_held = 1'b0;
               record_event(mevq_pkg::EV_LRELEASE);
            end else begin
               right_held = 1'b0;
               record_event(mevq_pkg::EV_RRELEASE);
            end
            if (!on_screen) begin
               r.capture_release = 1'b1;
               ptr_inside = 1'b0;
               record_event(mevq_pkg::EV_LEAVE);
            end
            // button categories share the message kind encoding
            r.category = m.kind;
         end
         mevq_pkg::KIND_WHEEL: begin
            delta = $signed(m.wheel_turn);
            wheel_carry += delta;
            while (wheel_carry >= mevq_pkg::NOTCH_COUNTS) begin
               wheel_carry -= mevq_pkg::NOTCH_COUNTS;
               record_event(mevq_pkg::EV_WHEELUP);
            end
            while (wheel_carry <= -mevq_pkg::NOTCH_COUNTS) begin
               wheel_carry += mevq_pkg::NOTCH_COUNTS;
               record_event(mevq_pkg::EV_WHEELDOWN);
            end
            r.category = (delta < 0) ? mevq_pkg::CAT_WHEEL_DOWN : mevq_pkg::CAT_WHEEL_UP;
         end
         mevq_pkg::KIND_READ: begin
            r.category = mevq_pkg::CAT_NONE;
            if (ring_count > 0) begin
               r.event_valid = 1'b1;
               r.event_type  = event_ring[ring_head].etype;
               r.event_x     = event_ring[ring_head].x;
               r.event_y     = event_ring[ring_head].y;
               r.event_left  = event_ring[ring_head].left;
               r.event_right = event_ring[ring_head].right;
               ring_head = (ring_head + 1) % QUEUE_DEPTH;
               ring_count--;
            end
         end
         mevq_pkg::KIND_FLUSH: begin
            r.category = mevq_pkg::CAT_NONE;
            ring_head = 0;
            ring_count = 0;
         end
      endcase
      r.in_window = ptr_inside;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   task automatic add_message(logic [2:0] kind, int x, int y, logic held, int delta);
      pending_type p;
      p = '0;
      p.msg.kind         = kind;
      p.msg.pos_x        = x[mevq_pkg::POS_W-1:0];
      p.msg.pos_y        = y[mevq_pkg::POS_W-1:0];
      p.msg.buttons_held = held;
      p.msg.wheel_turn   = delta[mevq_pkg::POS_W-1:0];
      pending_work.push_back(p);
   endtask

   task automatic add_window(int w, int h);
      pending_type p;
      p = '0;
      p.is_cfg = 1'b1;
      p.index  = mevq_pkg::CSR_WIDTH;
      p.value  = w[mevq_pkg::CFG_W-1:0];
      pending_work.push_back(p);
      p.index  = mevq_pkg::CSR_HEIGHT;
      p.value  = h[mevq_pkg::CFG_W-1:0];
      pending_work.push_back(p);
   endtask

   // Mostly inside the window, some on its edges, some anywhere
   function automatic int pick_coord(int extent);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6 && extent > 0)
         return $urandom_range(0, extent - 1);
      if (sel < 8)
         return ((sel == 6) ? -2 : extent - 2) + int'($urandom_range(0, 3));
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int pick_window();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return 0;
      if (sel == 1)
         return 1;
      if (sel == 2)
         return 32767;
      return $urandom_range(1, 1000);
   endfunction

   // Driver: present the next transaction after its gap; register writes wait for idle
   always @(negedge clock) begin : driver
      pending_type next_item;
      logic        drive_start;
      logic        drive_csr;
      logic        issued;
      drive_start = start;
      drive_csr   = csr_valid;
      issued      = 1'b0;
      if (!reset) begin
         if (start && msgs_taken == msgs_sent)
            drive_start = 1'b0;
         if (csr_valid && writes_taken == writes_sent)
            drive_csr = 1'b0;
         if (!drive_start && !drive_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_work.size() > 0) begin
               if (pending_work[0].is_cfg) begin
                  if (awaited_responses.size() == 0 && !busy) begin
                     next_item = pending_work.pop_front();
                     csr_index <= next_item.index;
                     csr_data  <= next_item.value;
                     drive_csr = 1'b1;
                     writes_sent++;
                     issued = 1'b1;
                  end
               end else begin
                  next_item = pending_work.pop_front();
                  req_data <= next_item.msg;
                  drive_start = 1'b1;
                  msgs_sent++;
                  issued = 1'b1;
               end
            end
         end
         // draw the gap that follows this transaction; flip into and out of burst stretches
         if (issued) begin
            gap_left = no_idle ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0)
               no_idle = !no_idle;
         end
         start     <= drive_start;
         csr_valid <= drive_csr;
      end
   end

   // Monitor: check responses, predict accepted messages, track register writes
   always @(posedge clock) begin : monitor
      mevq_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               failed = 1'b1;
            end else begin
               want = awaited_responses.pop_front();
               check_field("category", 16'(want.category), 16'(rsp_data.category));
               check_field("event_valid", 16'(want.event_valid), 16'(rsp_data.event_valid));
               check_field("event_type", 16'(want.event_type), 16'(rsp_data.event_type));
               check_field("event_x", want.event_x, rsp_data.event_x);
               check_field("event_y", want.event_y, rsp_data.event_y);
               check_field("event_left", 16'(want.event_left), 16'(rsp_data.event_left));
               check_field("event_right", 16'(want.event_right), 16'(rsp_data.event_right));
               check_field("capture_set", 16'(want.capture_set), 16'(rsp_data.capture_set));
               check_field("capture_release", 16'(want.capture_release),
                           16'(rsp_data.capture_release));
               check_field("in_window", 16'(want.in_window), 16'(rsp_data.in_window));
            end
         end
         if (start && !busy) begin
            awaited_responses.push_back(pointer_response(req_data));
            msgs_taken++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == mevq_pkg::CSR_WIDTH)
               win_w = csr_data;
            else
               win_h = csr_data;
            writes_taken++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mouse_event_queue regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int   w;
      int   h;
      int   pick;
      int   x;
      int   y;
      int   d;
      int   phase;
      int   n;
      int   k;
      logic btn;

      // Directed: empty read, enter, edges, repeated leave, drag outside
      add_message(mevq_pkg::KIND_READ, 5, 5, 1'b1, -1);
      add_message(mevq_pkg::KIND_MOVE, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_MOVE, 639, 479, 1'b0, 0);
      add_message(mevq_pkg::KIND_MOVE, 640, 10, 1'b0, 0);
      add_message(mevq_pkg::KIND_MOVE, -1, -1, 1'b0, 0);
      add_message(mevq_pkg::KIND_MOVE, -32768, 32767, 1'b1, 32767);
      // presses ignore the message position
      add_message(mevq_pkg::KIND_LDOWN, 1234, -5, 1'b0, 0);
      add_message(mevq_pkg::KIND_RDOWN, -32768, -32768, 1'b1, -32768);
      add_message(mevq_pkg::KIND_LUP, 10, 10, 1'b0, 0);
      add_message(mevq_pkg::KIND_RUP, 32767, -32768, 1'b0, 0);
      // wheel: one notch, carry to a notch down, full swings that overflow the queue
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, 120);
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, -119);
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, -1);
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, 32767);
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, -32768);
      add_message(mevq_pkg::KIND_WHEEL, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_READ, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_READ, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_FLUSH, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_READ, 0, 0, 1'b0, 0);
      // zero-sized window: nothing is inside
      add_window(0, 0);
      add_message(mevq_pkg::KIND_MOVE, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_LUP, 0, 0, 1'b0, 0);
      add_window(32767, 32767);
      add_message(mevq_pkg::KIND_MOVE, 32766, 32766, 1'b0, 0);
      add_window(1, 1);
      add_message(mevq_pkg::KIND_MOVE, 0, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_MOVE, 1, 0, 1'b0, 0);
      add_message(mevq_pkg::KIND_READ, 0, 0, 1'b0, 0);

      // Random phases, each under a fresh window size
      for (phase = 0; phase < 14; phase++) begin
         w = pick_window();
         h = pick_window();
         add_window(w, h);
         for (n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            x    = pick_coord(w);
            y    = pick_coord(h);
            d    = int'($urandom_range(0, 65535)) - 32768;
            btn  = $urandom_range(0, 1);
            if (pick < 30) begin
               add_message(mevq_pkg::KIND_MOVE, x, y, $urandom_range(0, 3) == 0, d);
            end else if (pick < 38) begin
               add_message(btn ? mevq_pkg::KIND_LDOWN : mevq_pkg::KIND_RDOWN, x, y, btn, d);
            end else if (pick < 48) begin
               add_message(btn ? mevq_pkg::KIND_LUP : mevq_pkg::KIND_RUP, x, y, !btn, d);
            end else if (pick < 62) begin
               k = $urandom_range(0, 9);
               if (k < 4)
                  d = (($urandom_range(0, 1) != 0) ? 120 : -120) * int'($urandom_range(1, 3));
               else if (k < 7)
                  d = int'($urandom_range(0, 600)) - 300;
               else if (k < 9)
                  d = int'($urandom_range(0, 40)) - 20;
               add_message(mevq_pkg::KIND_WHEEL, x, y, btn, d);
            end else if (pick < 66) begin
               // drag: press, moves with the button held, release anywhere
               add_message(btn ? mevq_pkg::KIND_LDOWN : mevq_pkg::KIND_RDOWN, x, y, 1'b0, d);
               for (k = 0; k < 3; k++)
                  add_message(mevq_pkg::KIND_MOVE, pick_coord(w), pick_coord(h), 1'b1, d);
               add_message(btn ? mevq_pkg::KIND_LUP : mevq_pkg::KIND_RUP,
                           pick_coord(w), pick_coord(h), 1'b0, d);
            end else if (pick < 96) begin
               add_message(mevq_pkg::KIND_READ, x, y, btn, d);
            end else begin
               add_message(mevq_pkg::KIND_FLUSH, x, y, btn, d);
            end
         end
      end

      // Hold reset, then release on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_work.size() > 0 || start || csr_valid || awaited_responses.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && awaited_responses.size() == 0)
         $display("mouse_event_queue regression: pass");
      else
         $display("mouse_event_queue regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mevq_pkg.sv
rtl/core/mevq_front.sv
rtl/core/mevq_opq.sv
rtl/core/mevq_back.sv
rtl/core/mouse_event_queue.sv
bench/tb.sv
